[design/mjpid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mjpid_pkg;

    // Joints served by the shared controller
    localparam int JOINT_COUNT = 7;
    localparam int JOINT_W     = 3;

    localparam int POS_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 32;
    localparam int DRIVE_W = 32;

    // Stream payload widths (packed fields, padded to whole bytes)
    localparam int S_FIELDS_W = JOINT_W + 4 * POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = JOINT_W + DRIVE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_DERIV_GAIN = 2'd1,
        CFG_INTEG_GAIN = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

[design/multi_joint_pid_controller_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Discrete PID controller shared by up to JOINT_COUNT joints. Each request names
// a joint and carries target/measured position and velocity (signed Q4.12); the
// block returns one drive value per request, (kp*e + kd*de)>>8 + (ki_dt*I)>>16,
// saturated to signed 32 bits with a clip flag. The per-joint integral is held in
// flip-flops, cleared at reset, and updated with saturation. The block takes one
// request per clock unless m_tready stalls the result register; a request goes
// from the input register through the integral update, multipliers and saturating
// adds into the result register, which drives m_tdata. A joint index at or beyond
// JOINT_COUNT leaves the integrals untouched and drops the I term. Gains must be
// written via the cfg port only with no request in flight; the block does not check.
module multi_joint_pid_controller_unit
    import mjpid_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    // joint_index[2:0], target_position[18:3], measured_position[34:19],
    // target_velocity[50:35], measured_velocity[66:51], zero pad above
    input  wire logic [S_TDATA_W-1:0]   s_tdata,

    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    // joint_echo[2:0], drive_value[34:3], zero pad above
    output      logic [M_TDATA_W-1:0]   m_tdata,
    // output_clipped[0]
    output      logic                   m_tuser,

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [GAIN_W-1:0]      cfg_data
);

    localparam logic [JOINT_W+1:0] JOINT_LIMIT = (JOINT_W + 2)'(JOINT_COUNT);

    // Configuration
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            deriv_gain_reg <= '0;
            integ_gain_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: input register feeds the result register
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    logic [JOINT_W-1:0]      joint_reg;
    logic signed [POS_W-1:0] tgt_pos_reg;
    logic signed [POS_W-1:0] meas_pos_reg;
    logic signed [POS_W-1:0] tgt_vel_reg;
    logic signed [POS_W-1:0] meas_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            joint_reg    <= s_tdata[JOINT_W-1:0];
            tgt_pos_reg  <= s_tdata[JOINT_W +: POS_W];
            meas_pos_reg <= s_tdata[JOINT_W + POS_W +: POS_W];
            tgt_vel_reg  <= s_tdata[JOINT_W + 2*POS_W +: POS_W];
            meas_vel_reg <= s_tdata[JOINT_W + 3*POS_W +: POS_W];
        end
    end

    // Datapath
    logic signed [POS_W:0]           err;
    logic signed [POS_W:0]           derr;
    logic signed [GAIN_W+POS_W:0]    p_prod;
    logic signed [GAIN_W+POS_W:0]    d_prod;
    logic signed [GAIN_W+POS_W+1:0]  pd_sum;
    logic signed [GAIN_W+POS_W-7:0]  pd_term;
    logic                            in_range;
    logic signed [INTEG_W-1:0]       integ_rd;
    logic signed [INTEG_W:0]         acc_sum;
    logic signed [INTEG_W-1:0]       acc_next;
    logic signed [GAIN_W+INTEG_W:0]  i_prod;
    logic signed [GAIN_W+INTEG_W-16:0] i_term;
    logic signed [DRIVE_W+1:0]       total;
    logic signed [DRIVE_W-1:0]       drive_sat;
    logic                            clipped;
    logic signed [INTEG_W-1:0]       integ_reg [JOINT_COUNT];

    assign err  = {tgt_pos_reg[POS_W-1], tgt_pos_reg} - {meas_pos_reg[POS_W-1], meas_pos_reg};
    assign derr = {tgt_vel_reg[POS_W-1], tgt_vel_reg} - {meas_vel_reg[POS_W-1], meas_vel_reg};

    assign p_prod  = $signed({{(POS_W+1){1'b0}}, prop_gain_reg})
                   * $signed({{GAIN_W{err[POS_W]}}, err});
    assign d_prod  = $signed({{(POS_W+1){1'b0}}, deriv_gain_reg})
                   * $signed({{GAIN_W{derr[POS_W]}}, derr});
    assign pd_sum  = {p_prod[GAIN_W+POS_W], p_prod} + {d_prod[GAIN_W+POS_W], d_prod};
    // arithmetic >> 8 (floor)
    assign pd_term = pd_sum[GAIN_W+POS_W+1:8];

    assign in_range = {2'b00, joint_reg} < JOINT_LIMIT;
    assign integ_rd = in_range ? integ_reg[joint_reg] : '0;

    assign acc_sum = {integ_rd[INTEG_W-1], integ_rd}
                   + {{(INTEG_W-POS_W){err[POS_W]}}, err};

    always_comb begin
        priority if (acc_sum[INTEG_W] != acc_sum[INTEG_W-1]) begin
            // overflow: clamp toward the sign of the true sum
            acc_next = acc_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            acc_next = acc_sum[INTEG_W-1:0];
        end
    end

    assign i_prod = $signed({{(INTEG_W+1){1'b0}}, integ_gain_reg})
                  * $signed({{(GAIN_W+1){acc_next[INTEG_W-1]}}, acc_next});
    assign i_term = in_range ? i_prod[GAIN_W+INTEG_W:16] : '0;

    assign total = {{(DRIVE_W+2-(GAIN_W+POS_W-6)){pd_term[GAIN_W+POS_W-7]}}, pd_term}
                 + {i_term[GAIN_W+INTEG_W-16], i_term};

    always_comb begin
        clipped   = 1'b0;
        drive_sat = total[DRIVE_W-1:0];
        if (total[DRIVE_W+1] && !(total[DRIVE_W] && total[DRIVE_W-1])) begin
            clipped   = 1'b1;
            drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else if (!total[DRIVE_W+1] && (total[DRIVE_W] || total[DRIVE_W-1])) begin
            clipped   = 1'b1;
            drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    // Integral store: updated as the request moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < JOINT_COUNT; k++) begin
                integ_reg[k] <= '0;
            end
        end else if (in_valid_reg && out_load && in_range) begin
            integ_reg[joint_reg] <= acc_next;
        end
    end

    // Result register
    logic [JOINT_W-1:0]        joint_out_reg;
    logic signed [DRIVE_W-1:0] drive_out_reg;
    logic                      clipped_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            joint_out_reg   <= joint_reg;
            drive_out_reg   <= drive_sat;
            clipped_out_reg <= clipped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, drive_out_reg, joint_out_reg};
    assign m_tuser  = clipped_out_reg;

endmodule

`default_nettype wire
